### rtl/core/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the range parity counter.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;
  localparam int FUNC_W  = 2;

  // request selector codes; the unused code counts odd elements
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_EVEN  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ODD   = 2'd2;

  localparam logic [COUNT_W-1:0] ECOUNT_RESET = 11'd1024;

  // one request as it reaches the sequencer
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
    logic              new_parity;
  } req_t;

endpackage

### rtl/core/rpc_ram.sv
// ----------------------------------------------------------------------------
// rpc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/rpc_ctrl.sv
// ----------------------------------------------------------------------------
// rpc_ctrl
// Sequencer that walks the odd-count tree with one shared adder.
// ----------------------------------------------------------------------------
module rpc_ctrl
  import rpc_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] elem_count,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [COUNT_W-1:0] res_count
);

  localparam int AW = $clog2(2 * MAX_ELEMENTS);
  localparam int NW = $clog2(2 * MAX_ELEMENTS + 1);
  localparam logic [NW-1:0] LEAF_BASE = NW'(MAX_ELEMENTS);
  localparam logic [AW-1:0] CLR_LAST  = AW'(2 * MAX_ELEMENTS - 1);
  localparam logic [NW-1:0] ROOT      = NW'(1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_UPD   = 7'b0000100,
    ST_QL    = 7'b0001000,
    ST_QR    = 7'b0010000,
    ST_QS    = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_cnt;
  logic [NW-1:0]      node;
  logic [NW-1:0]      l;
  logic [NW-1:0]      r;
  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] val;
  logic [COUNT_W-1:0] size;
  logic               pend;
  logic               is_even;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  logic [COUNT_W-1:0] used;
  logic [COUNT_W-1:0] used_m1;
  logic [POS_W-1:0]   last_c;
  logic               q_empty;
  logic [COUNT_W-1:0] q_size;
  logic               write_ok;
  logic [NW-1:0]      leaf_init;
  logic [NW-1:0]      r_init;
  logic [NW-1:0]      parent;
  logic [COUNT_W-1:0] add_out;
  logic               accept;

  // tree of odd counts, cleared to zero after reset
  rpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (2 * MAX_ELEMENTS)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_valid = (state == ST_DONE);
  assign res_count = is_even ? (size - sum) : sum;

  // range clipping and start nodes for a new request
  always_comb begin
    used      = (32'(elem_count) > MAX_ELEMENTS) ? COUNT_W'(MAX_ELEMENTS) : elem_count;
    used_m1   = used - COUNT_W'(1);
    last_c    = ({1'b0, req.last_pos} > used_m1) ? used_m1[POS_W-1:0] : req.last_pos;
    q_empty   = (used == '0) || (req.first_pos > last_c);
    q_size    = {1'b0, last_c} - {1'b0, req.first_pos} + COUNT_W'(1);
    write_ok  = 32'(req.first_pos) < MAX_ELEMENTS;
    leaf_init = NW'(req.first_pos) + LEAF_BASE;
    r_init    = NW'(last_c) + LEAF_BASE + NW'(1);
  end

  // shared adder: climb sum on update, range sum on query
  assign parent  = node >> 1;
  assign add_out = ((state == ST_UPD) ? val : sum) + ram_rdata;

  // tree port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_raddr = l[AW-1:0];
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_we    = accept && (req.func == FN_WRITE) && write_ok;
        ram_waddr = leaf_init[AW-1:0];
        ram_wdata = COUNT_W'(req.new_parity);
        ram_raddr = leaf_init[AW-1:0] ^ AW'(1);
      end
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = parent[AW-1:0];
        ram_wdata = add_out;
        ram_raddr = parent[AW-1:0] ^ AW'(1);
      end
      ST_QR: begin
        ram_raddr = r[AW-1:0] - AW'(1);
      end
      default: begin
        ram_raddr = l[AW-1:0];
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            is_even <= (req.func == FN_EVEN);
            if (req.func == FN_WRITE) begin
              node <= leaf_init;
              val  <= COUNT_W'(req.new_parity);
              if (write_ok) begin
                state <= ST_UPD;
              end
            end else begin
              sum  <= '0;
              pend <= 1'b0;
              l    <= leaf_init;
              r    <= r_init;
              size <= q_empty ? '0 : q_size;
              state <= q_empty ? ST_DONE : ST_QL;
            end
          end
        end
        ST_UPD: begin
          val  <= add_out;
          node <= parent;
          if (parent == ROOT) begin
            state <= ST_IDLE;
          end
        end
        ST_QL: begin
          if (l >= r) begin
            state <= ST_DONE;
          end else begin
            pend <= l[0];
            if (l[0]) begin
              l <= l + NW'(1);
            end
            state <= ST_QR;
          end
        end
        ST_QR: begin
          if (pend) begin
            sum <= add_out;
          end
          pend <= r[0];
          if (r[0]) begin
            r <= r - NW'(1);
          end
          state <= ST_QS;
        end
        ST_QS: begin
          if (pend) begin
            sum <= add_out;
          end
          l     <= l >> 1;
          r     <= r >> 1;
          state <= ST_QL;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/range_parity_counter.sv
// Write request: one tree level per cycle up the path to the root.
// Count request: each tree level of the range walk passes through ST_QL, ST_QR and ST_QS,
//   paced by the single read port of the tree memory.
// One request at a time; a finished result may wait in the output register meanwhile.
// Reset (rst, synchronous): a clearing pass zeroes every word of the tree,
//   s_tready stays low during it; element_count returns to 1024.
// ----------------------------------------------------------------------------
// range_parity_counter
// Parity store with range counts of even or odd elements over a segment tree.
// ----------------------------------------------------------------------------
module range_parity_counter
  import rpc_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,   // element_count
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,    // first_pos[9:0], last_pos[19:10], new_parity[20]
  input  logic [1:0]         s_tuser,    // func[1:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata     // count[10:0]
);

  logic [COUNT_W-1:0] elem_count;
  req_t               req;
  logic               res_valid;
  logic               res_ready;
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] m_count;

  // element count register
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= ECOUNT_RESET;
    end else if (cfg_we) begin
      elem_count <= cfg_data;
    end
  end

  // unpack the request
  assign req.func       = s_tuser;
  assign req.first_pos  = s_tdata[9:0];
  assign req.last_pos   = s_tdata[19:10];
  assign req.new_parity = s_tdata[20];

  rpc_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .elem_count (elem_count),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_count  (res_count)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_count <= res_count;
    end
  end

  assign m_tdata = {5'b0, m_count};

endmodule

### rtl/core/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the range parity counter, bound to the top level.
// ----------------------------------------------------------------------------
module rpc_checker
  import rpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a count never exceeds the largest range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:11] == 5'd0) && (m_tdata[10:0] <= 11'd1024))
    else $error("count out of range");

  // the clearing pass keeps requests out after reset
  a_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken during clearing pass");

  // a count request leaves the block busy in the cycle after it is accepted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != FN_WRITE) |=> !s_tready)
    else $error("ready right after a count request");

endmodule

bind range_parity_counter rpc_checker u_chk (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for range_parity_counter. Parity writes and even/odd
// range counts go in over the request stream. A local parity store predicts
// every count, and each count that comes back is checked in order against it.
// element_count is moved between phases through its extremes and random
// values. Both stream sides idle at random in bursts.
// ----------------------------------------------------------------------------
module tb;
  import rpc_pkg::*;

  localparam int MAX_ELEMENTS = 1024;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 110;
  // the spare selector code behaves as an odd count
  localparam logic [FUNC_W-1:0] FN_ODD_ALT = 2'd3;

  // predicts counts from a private parity store and checks them in order
  class parity_count_board;
    bit               parity_store [0:MAX_ELEMENTS-1];
    logic [COUNT_W-1:0] elem_count;
    logic [COUNT_W-1:0] expected_counts [$];
    int mismatches;
    int writes_seen;
    int counts_seen;
    int settings_seen;

    function new();
      for (int i = 0; i < MAX_ELEMENTS; i++) parity_store[i] = 1'b0;
      elem_count    = ECOUNT_RESET;
      mismatches    = 0;
      writes_seen   = 0;
      counts_seen   = 0;
      settings_seen = 0;
    endfunction

    function void set_elem_count(logic [COUNT_W-1:0] value);
      elem_count = value;
      settings_seen++;
    endfunction

    function logic [COUNT_W-1:0] predict_count(logic [FUNC_W-1:0] func,
                                               logic [POS_W-1:0] first,
                                               logic [POS_W-1:0] last);
      int used;
      int hi;
      int evens;
      int total;
      used  = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
      evens = 0;
      total = 0;
      if (used > 0) begin
        hi = (last > used - 1) ? used - 1 : last;
        if (first <= hi) begin
          for (int i = first; i <= hi; i++) if (!parity_store[i]) evens++;
          total = hi - first + 1;
          return (func == FN_EVEN) ? COUNT_W'(evens) : COUNT_W'(total - evens);
        end
      end
      return '0;
    endfunction

    // called at the edge where a request is accepted
    function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] first,
                               logic [POS_W-1:0] last, logic parity);
      if (func == FN_WRITE) begin
        if (first < MAX_ELEMENTS) parity_store[first] = parity;
        writes_seen++;
      end else begin
        expected_counts.push_back(predict_count(func, first, last));
        counts_seen++;
      end
    endfunction

    function void check_count(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("count %0d arrived with none pending", got);
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("count mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [23:0]        s_tdata;   // first_pos[9:0], last_pos[19:10], new_parity[20]
  logic [1:0]         s_tuser;   // func[1:0]
  logic               m_tvalid;
  logic               m_tready;
  logic [15:0]        m_tdata;   // count[10:0]

  parity_count_board board;
  bit quiet;
  int cycles = 0;
  int failures;

  range_parity_counter #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle count and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // result side: check every accepted count
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_count(m_tdata[COUNT_W-1:0]);
  end

  // result side back-pressure in random bursts
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  // one request, with an optional idle burst in front
  task automatic send_req(logic [FUNC_W-1:0] func, logic [POS_W-1:0] first,
                          logic [POS_W-1:0] last, logic parity);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tuser  = func;
    s_tdata  = {3'b000, parity, last, first};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_request(func, first, last, parity);
  endtask

  // hold the sender until every count is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // element_count write while idle
  task automatic set_count(logic [COUNT_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(posedge clk);
    board.set_elem_count(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random request shaped around the current element count
  task automatic rand_req();
    int eff;
    int pick;
    int a;
    int b;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    eff  = (board.elem_count == 0) ? 1 :
           (board.elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : board.elem_count;
    pick = $urandom_range(0, 19);
    if (pick < 8)       func = FN_WRITE;
    else if (pick < 13) func = FN_EVEN;
    else if (pick < 18) func = FN_ODD;
    else                func = FN_ODD_ALT;
    a = $urandom_range(0, eff - 1);
    b = $urandom_range(0, eff - 1);
    case ($urandom_range(0, 9))
      0, 1: begin
        first = POS_W'($urandom);
        last  = POS_W'($urandom);
      end
      2: begin
        first = POS_W'(a);
        last  = POS_W'($urandom_range(eff - 1, MAX_ELEMENTS - 1));
      end
      3: begin
        first = POS_W'((a > b) ? a : b);
        last  = POS_W'((a > b) ? b : a);
      end
      default: begin
        first = POS_W'((a < b) ? a : b);
        last  = POS_W'((a < b) ? b : a);
      end
    endcase
    send_req(func, first, last, 1'($urandom));
  endtask

  initial begin
    logic [COUNT_W-1:0] setting;
    board    = new();
    quiet    = 1'b0;
    failures = 0;
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: whole store, updates that overwrite, spare code, empty range
    send_req(FN_EVEN, 10'd0, 10'd1023, 1'b0);
    send_req(FN_ODD, 10'd0, 10'd1023, 1'b0);
    send_req(FN_WRITE, 10'd0, 10'd1023, 1'b1);
    send_req(FN_WRITE, 10'd1023, 10'd0, 1'b1);
    send_req(FN_WRITE, 10'd512, 10'd1023, 1'b1);
    send_req(FN_WRITE, 10'd512, 10'd0, 1'b0);
    send_req(FN_WRITE, 10'd512, 10'd1023, 1'b1);
    send_req(FN_EVEN, 10'd0, 10'd1023, 1'b1);
    send_req(FN_ODD_ALT, 10'd0, 10'd1023, 1'b0);
    send_req(FN_ODD, 10'd1023, 10'd1023, 1'b0);
    send_req(FN_ODD, 10'd600, 10'd5, 1'b0);
    send_req(FN_EVEN, 10'd0, 10'd0, 1'b0);

    // smallest count, clipping, write above the count
    set_count(11'd1);
    send_req(FN_ODD, 10'd0, 10'd1023, 1'b0);
    send_req(FN_EVEN, 10'd1, 10'd1, 1'b0);
    send_req(FN_WRITE, 10'd700, 10'd3, 1'b1);

    // zero elements in use
    set_count(11'd0);
    send_req(FN_EVEN, 10'd0, 10'd0, 1'b0);
    send_req(FN_ODD_ALT, 10'd0, 10'd1023, 1'b0);

    // count above the store acts as the full store
    set_count(11'd2047);
    send_req(FN_ODD, 10'd0, 10'd1023, 1'b0);

    set_count(11'd600);
    send_req(FN_ODD, 10'd500, 10'd1023, 1'b0);
    send_req(FN_EVEN, 10'd599, 10'd599, 1'b0);

    // random phases, each under its own element count
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: setting = 11'd1024;
        1: setting = 11'd1;
        2: setting = 11'd2047;
        3: setting = 11'd0;
        default: begin
          if ($urandom_range(0, 4) == 0) setting = COUNT_W'($urandom_range(1025, 2047));
          else                           setting = COUNT_W'($urandom_range(1, 1024));
        end
      endcase
      set_count(setting);
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) rand_req();
    end

    drain();
    failures = board.mismatches;
    if (board.pending() > 0) begin
      $display("%0d counts never arrived", board.pending());
      failures += board.pending();
    end
    $display("ran %0d parity writes and %0d range counts", board.writes_seen,
             board.counts_seen);
    $display("under %0d element count settings, extremes included", board.settings_seen);
    if (failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/rpc_pkg.sv
rtl/core/rpc_ram.sv
rtl/core/rpc_ctrl.sv
rtl/core/range_parity_counter.sv
rtl/core/rpc_checker.sv
dv/tb.sv
